FILE: rtl/signed_int_to_decimal_ascii_unit_defines.svh
// signed_int_to_decimal_ascii_unit_defines.svh
// assertion macros shared by the rtl files, no dependencies
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ITOA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itoa assertion failed");

// next-cycle implication, disabled while reset is low
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itoa assertion failed");

`endif

FILE: rtl/itoa_pkg.sv
// itoa_pkg.sv
// types and constants for the integer to decimal text unit
// no dependencies
package itoa_pkg;

    localparam logic [6:0] ASCII_ZERO  = 7'd48;
    localparam logic [6:0] ASCII_MINUS = 7'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    // commands from the sequencer to the bcd unit
    typedef struct packed {
        logic load;
        logic step;
        logic shift_digit;
    } t_bcd_ctl;

endpackage

FILE: rtl/itoa_bcd_unit.sv
// itoa_bcd_unit.sv
// shared shift / add-3 unit: binary magnitude to bcd, then digit shift-out
// depends on itoa_pkg
module itoa_bcd_unit #(
    parameter int VALUE_WIDTH = 32,
    parameter int NUM_DIGITS  = 10
) (
    input  logic                     i_clk,
    input  itoa_pkg::t_bcd_ctl       i_ctl,
    input  logic [VALUE_WIDTH-1:0]   i_load_value,
    output logic [3:0]               o_top_digit
);
    import itoa_pkg::*;

    localparam int BCD_W = 4 * NUM_DIGITS;

    logic [VALUE_WIDTH-1:0] r_bin;
    logic [VALUE_WIDTH-1:0] n_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       n_bcd;
    logic [BCD_W-1:0]       adj_bcd;

    // add 3 to every digit of 5 or more
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj_bcd[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj_bcd[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // load, dabble step or digit shift
    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_ctl.load) begin
            n_bin = i_load_value;
            n_bcd = '0;
        end else if (i_ctl.step) begin
            n_bcd = {adj_bcd[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
            n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
        end else if (i_ctl.shift_digit) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

FILE: rtl/signed_int_to_decimal_ascii_unit.sv
// signed_int_to_decimal_ascii_unit.sv
// top level: sequencer, sign handling and output register around itoa_bcd_unit
// depends on itoa_pkg, itoa_bcd_unit and the assertion macro header
//
//   channel  valid        stall         payload
//   input    i_in_valid   o_in_stall    i_value
//   output   o_out_valid  i_out_stall   o_char_code, o_last
//
// one value takes VALUE_WIDTH shift steps of the bcd unit (32 at default),
// then one digit shift per suppressed leading zero, then the characters;
// a new value is not taken until the sequencer is back in idle after the
// last character, since the single bcd unit holds one value at a time.
// input is taken only in idle; the output register may still hold the last
// character then. output stalls hold the sequencer in sign or emit.
// synchronous active-low reset clears the sequencer and the output valid.
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [6:0]             o_char_code,
    output logic                   o_last
);
    import itoa_pkg::*;

    // decimal digits of 2^(VALUE_WIDTH-1), using 1233/4096 for log10(2)
    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;
    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    t_state                 r_state;
    t_state                 n_state;
    logic [BIT_CNT_W-1:0]   r_bit;
    logic [BIT_CNT_W-1:0]   n_bit;
    logic [DIG_CNT_W-1:0]   r_dig;
    logic [DIG_CNT_W-1:0]   n_dig;
    logic                   r_neg;
    logic                   n_neg;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [6:0]             r_char;
    logic [6:0]             n_char;
    logic                   r_last;
    logic                   n_last;

    t_bcd_ctl               bcd_ctl;
    logic [3:0]             top_digit;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic                   in_xfer;
    logic                   out_free;

    // handshake
    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // unsigned magnitude; most negative value gives 2^(VALUE_WIDTH-1)
    assign magnitude = i_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~i_value + 1'b1) : i_value;

    itoa_bcd_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_bcd (
        .i_clk        (i_clk),
        .i_ctl        (bcd_ctl),
        .i_load_value (magnitude),
        .o_top_digit  (top_digit)
    );

    // sequencer next state and output register load
    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_dig       = r_dig;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && i_out_stall;
        n_char      = r_char;
        n_last      = r_last;
        bcd_ctl     = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    bcd_ctl.load = 1'b1;
                    n_neg        = i_value[VALUE_WIDTH-1];
                    n_bit        = BIT_CNT_W'(VALUE_WIDTH);
                    n_state      = S_CONV;
                end
            end
            S_CONV: begin
                bcd_ctl.step = 1'b1;
                n_bit        = r_bit - 1'b1;
                if (r_bit == BIT_CNT_W'(1)) begin
                    n_dig   = DIG_CNT_W'(NUM_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (top_digit == 4'd0 && r_dig > DIG_CNT_W'(1)) begin
                    bcd_ctl.shift_digit = 1'b1;
                    n_dig               = r_dig - 1'b1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = ASCII_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_char              = ASCII_ZERO + {3'b000, top_digit};
                    n_last              = (r_dig == DIG_CNT_W'(1));
                    bcd_ctl.shift_digit = 1'b1;
                    n_dig               = r_dig - 1'b1;
                    if (r_dig == DIG_CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_dig       <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_dig       <= n_dig;
            r_neg       <= n_neg;
            r_out_valid <= n_out_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    // checks
    `ITOA_ASSERT_IMPL(a_char_range, i_clk, i_rst_n, r_out_valid,
        (r_char == ASCII_MINUS || (r_char >= ASCII_ZERO && r_char <= ASCII_ZERO + 7'd9)))
    `ITOA_ASSERT_IMPL(a_sign_not_last, i_clk, i_rst_n,
        (r_out_valid && r_char == ASCII_MINUS), !r_last)
    `ITOA_ASSERT_NEXT(a_accept_starts_conv, i_clk, i_rst_n, in_xfer, (r_state == S_CONV))
    `ITOA_ASSERT_IMPL(a_emit_has_digits, i_clk, i_rst_n, (r_state == S_EMIT),
        (r_dig != '0))

endmodule
